/* hw/rtl/dlvl_pkg.sv */
// ----------------------------------------------------------------------------
// dlvl_pkg
// Types, codes and constants shared by the value list cells, the channel
// interfaces and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package dlvl_pkg;

  localparam int DEF_CAPACITY = 64;
  localparam int FUNC_W       = 4;
  localparam int VAL_W        = 32;
  localparam int STATUS_W     = 2;
  localparam int LEN_W        = 7;

  localparam logic [FUNC_W-1:0] FN_PUSH_FRONT = 4'd0;
  localparam logic [FUNC_W-1:0] FN_PUSH_BACK  = 4'd1;
  localparam logic [FUNC_W-1:0] FN_INS_AFTER  = 4'd2;
  localparam logic [FUNC_W-1:0] FN_INS_BEFORE = 4'd3;
  localparam logic [FUNC_W-1:0] FN_PEEK_FRONT = 4'd4;
  localparam logic [FUNC_W-1:0] FN_PEEK_BACK  = 4'd5;
  localparam logic [FUNC_W-1:0] FN_POP_FRONT  = 4'd6;
  localparam logic [FUNC_W-1:0] FN_POP_BACK   = 4'd7;
  localparam logic [FUNC_W-1:0] FN_REMOVE     = 4'd8;
  localparam logic [FUNC_W-1:0] FN_FIND       = 4'd9;

  localparam logic [STATUS_W-1:0] STS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STS_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] STS_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] STS_FULL      = 2'd3;

  typedef enum logic [3:0] {
    CA_HOLD,
    CA_MATCH,
    CA_SCAN,
    CA_PUSH_FRONT,
    CA_PUSH_BACK,
    CA_INS_AFTER,
    CA_INS_BEFORE,
    CA_POP_FRONT,
    CA_POP_BACK,
    CA_REMOVE
  } cell_act_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MATCH,
    ST_SCAN,
    ST_APPLY
  } state_t;

  typedef struct packed {
    logic             valid;
    logic [VAL_W-1:0] value;
    logic             match;
    logic             prior;
  } cell_state_t;

  typedef struct packed {
    cell_act_t        action;
    logic [VAL_W-1:0] item;
    logic [VAL_W-1:0] target;
  } cell_ctrl_t;

endpackage

`default_nettype wire

/* hw/rtl/dlvl_req_if.sv */
// ----------------------------------------------------------------------------
// dlvl_req_if
// Request channel: operation code, item value and key value.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlvl_req_if;
  logic                                valid;
  logic                                ready;
  logic        [dlvl_pkg::FUNC_W-1:0]  func;
  logic signed [dlvl_pkg::VAL_W-1:0]   item_value;
  logic signed [dlvl_pkg::VAL_W-1:0]   key_value;

  modport source(output valid, func, item_value, key_value, input ready);
  modport sink(input valid, func, item_value, key_value, output ready);
endinterface

`default_nettype wire

/* hw/rtl/dlvl_rsp_if.sv */
// ----------------------------------------------------------------------------
// dlvl_rsp_if
// Response channel: status, value read, found flag, length and empty flag.
// ----------------------------------------------------------------------------
`default_nettype none

interface dlvl_rsp_if;
  logic                                 valid;
  logic                                 ready;
  logic        [dlvl_pkg::STATUS_W-1:0] status;
  logic signed [dlvl_pkg::VAL_W-1:0]    read_value;
  logic                                 found;
  logic        [dlvl_pkg::LEN_W-1:0]    length;
  logic                                 empty_res;

  modport source(output valid, status, read_value, found, length, empty_res,
                 input ready);
  modport sink(input valid, status, read_value, found, length, empty_res,
               output ready);
endinterface

`default_nettype wire

/* hw/rtl/dlvl_cell.sv */
// ----------------------------------------------------------------------------
// dlvl_cell
// One list position. It holds a value, compares it with the search target and
// passes the earlier-match flag to its right neighbor one cell per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dlvl_cell (
  input  logic                   clk,
  input  logic                   rst,
  input  dlvl_pkg::cell_ctrl_t   ctrl,
  input  dlvl_pkg::cell_state_t  left,
  input  dlvl_pkg::cell_state_t  right,
  output dlvl_pkg::cell_state_t  self
);
  import dlvl_pkg::*;

  cell_state_t cur;
  cell_state_t cur_next;
  logic        first_self;
  logic        left_first;

  assign first_self = cur.match & ~cur.prior;
  assign left_first = left.match & ~left.prior;

  always_comb begin
    cur_next = cur;
    case (ctrl.action)
      CA_MATCH: begin
        cur_next.match = cur.valid & (cur.value == ctrl.target);
        cur_next.prior = 1'b0;
      end
      CA_SCAN: begin
        cur_next.prior = left.prior | left.match;
      end
      CA_PUSH_FRONT: begin
        cur_next.valid = left.valid;
        cur_next.value = left.value;
      end
      CA_PUSH_BACK: begin
        if (!cur.valid && left.valid) begin
          cur_next.valid = 1'b1;
          cur_next.value = ctrl.item;
        end
      end
      CA_INS_AFTER: begin
        if (cur.prior) begin
          cur_next.valid = left_first ? 1'b1 : left.valid;
          cur_next.value = left_first ? ctrl.item : left.value;
        end
      end
      CA_INS_BEFORE: begin
        if (first_self) begin
          cur_next.valid = 1'b1;
          cur_next.value = ctrl.item;
        end else if (cur.prior) begin
          cur_next.valid = left.valid;
          cur_next.value = left.value;
        end
      end
      CA_POP_FRONT: begin
        cur_next.valid = right.valid;
        cur_next.value = right.value;
      end
      CA_POP_BACK: begin
        if (cur.valid && !right.valid) begin
          cur_next.valid = 1'b0;
        end
      end
      CA_REMOVE: begin
        if (first_self || cur.prior) begin
          cur_next.valid = right.valid;
          cur_next.value = right.value;
        end
      end
      default: begin
        cur_next = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    cur.value <= cur_next.value;
    if (rst) begin
      cur.valid <= 1'b0;
      cur.match <= 1'b0;
      cur.prior <= 1'b0;
    end else begin
      cur.valid <= cur_next.valid;
      cur.match <= cur_next.match;
      cur.prior <= cur_next.prior;
    end
  end

  assign self = cur;

endmodule

`default_nettype wire

/* hw/rtl/doubly_linked_value_list.sv */
// ----------------------------------------------------------------------------
// doubly_linked_value_list
// Ordered list of signed values held in a row of cells, in list order from
// the head. Supports pushes, inserts around a key, peeks, pops, removal and
// search, one request at a time, with a registered response.
// ----------------------------------------------------------------------------
//   Channel  Dir  Handshake     Payload
//   req      in   valid/ready   func, item_value, key_value
//   rsp      out  valid/ready   status, read_value, found, length, empty_res
//
// Push, peek and pop requests go from acceptance straight to the apply state.
// Insert, remove and find first pass through the match and scan states: the
// first-match flag ripples through the row of cells one cell per cycle.
// Reset empties the list at once; a request may be accepted while the previous
// response is still waiting, and the block stalls before writing a new one.
`default_nettype none

module doubly_linked_value_list #(
  parameter int CAPACITY = dlvl_pkg::DEF_CAPACITY
) (
  input  logic          clk,
  input  logic          rst,
  dlvl_req_if.sink      req,
  dlvl_rsp_if.source    rsp
);
  import dlvl_pkg::*;

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int SCNT_W = $clog2(CAPACITY);
  localparam logic [SCNT_W-1:0] SCAN_LAST = SCNT_W'(CAPACITY - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(CAPACITY);

  state_t              state;
  state_t              state_next;
  logic [SCNT_W-1:0]   scan_cnt;
  logic [FUNC_W-1:0]   func_q;
  logic [VAL_W-1:0]    item_q;
  logic [VAL_W-1:0]    key_q;
  logic [CNT_W-1:0]    cnt;
  logic [CNT_W-1:0]    cnt_next;

  logic                out_valid;
  logic [STATUS_W-1:0] out_status;
  logic [VAL_W-1:0]    out_read;
  logic                out_found;

  logic [STATUS_W-1:0] res_status;
  logic [VAL_W-1:0]    res_read;
  logic                res_found;
  logic                apply_fire;
  logic                hit;
  logic [VAL_W-1:0]    tail_value;
  cell_act_t           apply_act;

  cell_ctrl_t          ctrl;
  cell_state_t         cell_o [CAPACITY];
  cell_state_t         left_edge;
  cell_state_t         right_edge;

  assign left_edge  = '{valid: 1'b1, value: item_q, match: 1'b0, prior: 1'b0};
  assign right_edge = '{valid: 1'b0, value: '0, match: 1'b0, prior: 1'b0};

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    dlvl_cell u_cell (
      .clk   (clk),
      .rst   (rst),
      .ctrl  (ctrl),
      .left  ((i == 0) ? left_edge : cell_o[(i == 0) ? 0 : i - 1]),
      .right ((i == CAPACITY - 1) ? right_edge
                                  : cell_o[(i == CAPACITY - 1) ? i : i + 1]),
      .self  (cell_o[i])
    );
  end

  always_comb begin
    tail_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (cell_o[i].valid &&
          (i == CAPACITY - 1 || !cell_o[(i == CAPACITY - 1) ? i : i + 1].valid))
        tail_value = tail_value | cell_o[i].value;
    end
  end

  assign hit        = cell_o[CAPACITY-1].prior | cell_o[CAPACITY-1].match;
  assign apply_fire = (state == ST_APPLY) && (!out_valid || rsp.ready);

  always_comb begin
    res_status = STS_OK;
    res_read   = '0;
    res_found  = 1'b0;
    apply_act  = CA_HOLD;
    cnt_next   = cnt;
    case (func_q)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (cnt == CNT_FULL) begin
          res_status = STS_FULL;
        end else begin
          apply_act = (func_q == FN_PUSH_FRONT) ? CA_PUSH_FRONT : CA_PUSH_BACK;
          cnt_next  = cnt + 1'b1;
        end
      end
      FN_INS_AFTER, FN_INS_BEFORE: begin
        if (!hit) begin
          res_status = STS_NOT_FOUND;
        end else if (cnt == CNT_FULL) begin
          res_status = STS_FULL;
        end else begin
          apply_act = (func_q == FN_INS_AFTER) ? CA_INS_AFTER : CA_INS_BEFORE;
          cnt_next  = cnt + 1'b1;
        end
      end
      FN_PEEK_FRONT, FN_PEEK_BACK, FN_POP_FRONT, FN_POP_BACK: begin
        if (cnt == '0) begin
          res_status = STS_EMPTY;
        end else begin
          res_read = (func_q == FN_PEEK_FRONT || func_q == FN_POP_FRONT)
                     ? cell_o[0].value : tail_value;
          if (func_q == FN_POP_FRONT) begin
            apply_act = CA_POP_FRONT;
            cnt_next  = cnt - 1'b1;
          end else if (func_q == FN_POP_BACK) begin
            apply_act = CA_POP_BACK;
            cnt_next  = cnt - 1'b1;
          end
        end
      end
      FN_REMOVE: begin
        if (!hit) begin
          res_status = STS_NOT_FOUND;
        end else begin
          apply_act = CA_REMOVE;
          cnt_next  = cnt - 1'b1;
        end
      end
      FN_FIND: begin
        if (!hit) res_status = STS_NOT_FOUND;
        else res_found = 1'b1;
      end
      default: begin
        res_status = STS_OK;
      end
    endcase
  end

  always_comb begin
    state_next  = state;
    ctrl.item   = item_q;
    ctrl.target = (func_q == FN_REMOVE || func_q == FN_FIND) ? item_q : key_q;
    ctrl.action = CA_HOLD;
    case (state)
      ST_IDLE: begin
        if (req.valid) begin
          if (req.func inside {FN_INS_AFTER, FN_INS_BEFORE, FN_REMOVE, FN_FIND})
            state_next = ST_MATCH;
          else
            state_next = ST_APPLY;
        end
      end
      ST_MATCH: begin
        ctrl.action = CA_MATCH;
        state_next  = ST_SCAN;
      end
      ST_SCAN: begin
        ctrl.action = CA_SCAN;
        if (scan_cnt == SCAN_LAST) state_next = ST_APPLY;
      end
      ST_APPLY: begin
        if (apply_fire) begin
          ctrl.action = apply_act;
          state_next  = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      scan_cnt  <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_SCAN) scan_cnt <= scan_cnt + 1'b1;
      else scan_cnt <= '0;
      if (apply_fire) begin
        cnt       <= cnt_next;
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req.valid) begin
      func_q <= req.func;
      item_q <= req.item_value;
      key_q  <= req.key_value;
    end
    if (apply_fire) begin
      out_status <= res_status;
      out_read   <= res_read;
      out_found  <= res_found;
    end
  end

  assign req.ready      = (state == ST_IDLE);
  assign rsp.valid      = out_valid;
  assign rsp.status     = out_status;
  assign rsp.read_value = out_read;
  assign rsp.found      = out_found;
  assign rsp.length     = LEN_W'(cnt);
  assign rsp.empty_res  = (cnt == '0);

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_FULL) else $error("entry count above capacity");

  a_head_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> cell_o[0].valid == (cnt != '0))
    else $error("head cell occupancy disagrees with count");

  a_last_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> cell_o[CAPACITY-1].valid == (cnt == CNT_FULL))
    else $error("last cell occupancy disagrees with count");

  a_found_ok: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.found |-> rsp.status == STS_OK)
    else $error("found flag with failing status");

endmodule

`default_nettype wire

/* bench/doubly_linked_value_list_channels.sv */
// ----------------------------------------------------------------------------
// doubly_linked_value_list_channels
// Interfaces used by the bench are the block's own request and response
// channels; this file only holds a small bundle of bench-side types.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package dlvl_bench_pkg;
  import dlvl_pkg::*;

  typedef struct packed {
    logic [FUNC_W-1:0]  func;
    logic [VAL_W-1:0]   item_value;
    logic [VAL_W-1:0]   key_value;
  } request_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [VAL_W-1:0]    read_value;
    logic                found;
    logic [LEN_W-1:0]    length;
    logic                empty_res;
  } response_t;
endpackage

/* bench/doubly_linked_value_list_test.sv */
// ----------------------------------------------------------------------------
// doubly_linked_value_list_test
// Drives list requests with random gaps, predicts every response with an
// array-based list model and compares responses field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module doubly_linked_value_list_test;
  import dlvl_pkg::*;
  import dlvl_bench_pkg::*;

  localparam int CAP = DEF_CAPACITY;

  logic clk = 1'b0;
  logic rst = 1'b1;

  dlvl_req_if req ();
  dlvl_rsp_if rsp ();

  doubly_linked_value_list dut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  request_t  pending_requests[$];
  response_t expected_responses[$];
  logic [VAL_W-1:0] list_model[$];
  int errors = 0;
  bit hold_sender = 0;
  bit req_taken = 0;
  int send_gap = 0;
  int recv_gap = 0;

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("error: %s got %0h expected %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic int locate(input logic [VAL_W-1:0] v);
    foreach (list_model[i]) if (list_model[i] == v) return i;
    return -1;
  endfunction

  function automatic response_t apply_request(input request_t r);
    response_t o;
    int e;
    o = '0;
    o.status = STS_OK;
    case (r.func)
      FN_PUSH_FRONT, FN_PUSH_BACK: begin
        if (list_model.size() >= CAP) o.status = STS_FULL;
        else if (r.func == FN_PUSH_FRONT) list_model.push_front(r.item_value);
        else list_model.push_back(r.item_value);
      end
      FN_INS_AFTER, FN_INS_BEFORE: begin
        e = locate(r.key_value);
        if (e < 0) o.status = STS_NOT_FOUND;
        else if (list_model.size() >= CAP) o.status = STS_FULL;
        else if (r.func == FN_INS_AFTER) list_model.insert(e + 1, r.item_value);
        else list_model.insert(e, r.item_value);
      end
      FN_PEEK_FRONT, FN_PEEK_BACK, FN_POP_FRONT, FN_POP_BACK: begin
        if (list_model.size() == 0) o.status = STS_EMPTY;
        else if (r.func == FN_PEEK_FRONT) o.read_value = list_model[0];
        else if (r.func == FN_PEEK_BACK) o.read_value = list_model[$];
        else if (r.func == FN_POP_FRONT) o.read_value = list_model.pop_front();
        else o.read_value = list_model.pop_back();
      end
      FN_REMOVE: begin
        e = locate(r.item_value);
        if (e < 0) o.status = STS_NOT_FOUND;
        else list_model.delete(e);
      end
      FN_FIND: begin
        if (locate(r.item_value) < 0) o.status = STS_NOT_FOUND;
        else o.found = 1'b1;
      end
      default: ;
    endcase
    o.length = LEN_W'(list_model.size());
    o.empty_res = (list_model.size() == 0);
    return o;
  endfunction

  // Values mostly from a small pool so that keys hit often.
  function automatic logic [VAL_W-1:0] pick_value();
    case ($urandom_range(0, 3))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
      default: return $urandom_range(0, 11) - 6;
    endcase
  endfunction

  function automatic request_t make_request(input int fn, input logic [VAL_W-1:0] iv,
                                            input logic [VAL_W-1:0] kv);
    request_t r;
    r.func = FUNC_W'(fn);
    r.item_value = iv;
    r.key_value = kv;
    return r;
  endfunction

  always @(posedge clk) begin
    req_taken <= req.valid && req.ready;
  end

  always @(negedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      req.func <= '0;
      req.item_value <= '0;
      req.key_value <= '0;
    end else if (req.valid && !req_taken) begin
    end else if (send_gap > 0) begin
      req.valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (pending_requests.size() > 0 &&
                 !(hold_sender && expected_responses.size() > 0)) begin
      request_t r;
      r = pending_requests.pop_front();
      req.valid <= 1'b1;
      req.func <= r.func;
      req.item_value <= r.item_value;
      req.key_value <= r.key_value;
      send_gap <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
    end else begin
      req.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
    end else if (recv_gap > 0) begin
      rsp.ready <= 1'b0;
      recv_gap <= recv_gap - 1;
    end else begin
      rsp.ready <= 1'b1;
      if (rsp.valid && rsp.ready) recv_gap <= $urandom_range(0, 7);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (req.valid && req.ready) begin
        request_t r;
        r = make_request(req.func, req.item_value, req.key_value);
        expected_responses.push_back(apply_request(r));
      end
      if (rsp.valid && rsp.ready) begin
        response_t w;
        if (expected_responses.size() == 0) begin
          report("unexpected response", 0, 0);
        end else begin
          w = expected_responses.pop_front();
          if (rsp.status !== w.status) report("status", rsp.status, w.status);
          if (rsp.read_value !== w.read_value)
            report("read_value", rsp.read_value, w.read_value);
          if (rsp.found !== w.found) report("found", rsp.found, w.found);
          if (rsp.length !== w.length) report("length", rsp.length, w.length);
          if (rsp.empty_res !== w.empty_res)
            report("empty_res", rsp.empty_res, w.empty_res);
        end
      end
    end
  end

  initial begin
    int fn;
    int bias;
    logic [VAL_W-1:0] iv;
    pending_requests.push_back(make_request(FN_PEEK_FRONT, 0, 0));
    pending_requests.push_back(make_request(FN_POP_BACK, 0, 0));
    pending_requests.push_back(make_request(FN_INS_AFTER, 1, 2));
    pending_requests.push_back(make_request(FN_PUSH_BACK, 32'h7fffffff, 0));
    pending_requests.push_back(make_request(FN_PUSH_FRONT, 32'h80000000, 0));
    pending_requests.push_back(make_request(FN_INS_AFTER, 5, 32'h80000000));
    pending_requests.push_back(make_request(FN_INS_BEFORE, 5, 32'h7fffffff));
    pending_requests.push_back(make_request(FN_PEEK_BACK, 0, 0));
    pending_requests.push_back(make_request(FN_FIND, 5, 0));
    pending_requests.push_back(make_request(FN_FIND, 6, 0));
    pending_requests.push_back(make_request(FN_REMOVE, 5, 0));
    pending_requests.push_back(make_request(FN_REMOVE, 9, 0));
    pending_requests.push_back(make_request(4'd10, 0, 0));
    pending_requests.push_back(make_request(4'd15, 32'hffffffff, 32'hffffffff));
    pending_requests.push_back(make_request(FN_POP_FRONT, 0, 0));
    pending_requests.push_back(make_request(FN_POP_BACK, 0, 0));
    pending_requests.push_back(make_request(FN_POP_BACK, 0, 0));
    pending_requests.push_back(make_request(FN_POP_FRONT, 0, 0));
    for (int i = 0; i < 66; i++)
      pending_requests.push_back(make_request(i[0] ? FN_PUSH_BACK : FN_PUSH_FRONT, i, 0));
    pending_requests.push_back(make_request(FN_INS_AFTER, 1, 3));
    pending_requests.push_back(make_request(FN_INS_BEFORE, 1, 1000));
    for (int i = 0; i < 2000; i++) begin
      bias = (i / 250) % 2;
      case ($urandom_range(0, 9))
        0, 1, 2: fn = bias ? $urandom_range(6, 8) : $urandom_range(0, 1);
        3, 4: fn = $urandom_range(2, 3);
        5, 6: fn = $urandom_range(4, 7);
        7, 8: fn = $urandom_range(8, 9);
        default: fn = $urandom_range(0, 15);
      endcase
      iv = pick_value();
      pending_requests.push_back(make_request(fn, iv, pick_value()));
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    wait (pending_requests.size() < 1000);
    hold_sender = 1'b1;
    wait (expected_responses.size() == 0);
    hold_sender = 1'b0;
    wait (pending_requests.size() == 0 && !req.valid);
    wait (expected_responses.size() == 0);
    repeat (2 * CAP + 20) @(posedge clk);
    if (errors == 0 && expected_responses.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
